>>> sv/lzfd_pkg.sv
// Shared types and constants for the LZF block decompressor.
package lzfd_pkg;

  localparam int CHUNK_BYTES = 8;
  localparam logic [7:0] LIT_LIMIT = 8'd32;   // control bytes below this start a literal run
  localparam int LEN_SHIFT = 5;
  localparam logic [2:0] LEN_EXTENDED = 3'd7; // length code that pulls in an extra byte

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_OVERFLOW     = 2'd1,
    ERR_TRUNCATED    = 2'd2,
    ERR_BEFORE_START = 2'd3
  } err_t;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t [CHUNK_BYTES-1:0] data;
    logic [3:0]              count;
    logic                    run_last;
    logic                    block_done;
    err_t                    err;
  } out_item_t;

  typedef struct packed {
    logic [8:0] total;       // bytes to copy, 3..264
    logic       block_done;  // reference carried the final input byte
  } copy_cmd_t;

endpackage

>>> sv/lzfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> sv/lzfd_copy.sv
// Back-reference copy engine: reads the history ring, writes it back, packs 8-byte chunks.
module lzfd_copy #(
  parameter int AW = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lzfd_pkg::copy_cmd_t cmd,
  input  logic [AW-1:0]       src_addr,
  input  logic [AW-1:0]       dst_addr,
  output logic                busy,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic                chunk_valid,
  input  logic                chunk_ready,
  output lzfd_pkg::out_item_t chunk
);
  import lzfd_pkg::*;

  logic [8:0]                   issue_left;
  logic [8:0]                   take_left;
  logic [AW-1:0]                rd_ptr;
  logic [AW-1:0]                wr_ptr;
  logic                         rd_pending;
  logic                         fwd;
  logic [7:0]                   fwd_data;
  logic [2:0]                   fill;
  byte_t [CHUNK_BYTES-1:0]      data_buf;
  logic [3:0]                   chunk_cnt;
  logic                         chunk_final;
  logic                         block_end;

  logic [7:0] cur_data;
  logic       consume;
  logic       issue;
  logic       last_take;
  logic       close;

  // distance 1 reads the byte being written this cycle: forward it
  assign cur_data  = fwd ? fwd_data : rd_data;
  assign consume   = rd_pending && !chunk_valid;
  assign issue     = busy && (issue_left != 9'd0) && (!rd_pending || consume);
  assign last_take = (take_left == 9'd1);
  assign close     = consume && ((fill == 3'd7) || last_take);

  assign rd_en   = issue;
  assign rd_addr = rd_ptr;
  assign wr_en   = consume;
  assign wr_addr = wr_ptr;
  assign wr_data = cur_data;

  always_comb begin
    for (int i = 0; i < CHUNK_BYTES; i++) begin
      chunk.data[i] = (4'(i) < chunk_cnt) ? data_buf[i] : 8'd0;
    end
    chunk.count      = chunk_cnt;
    chunk.run_last   = chunk_final;
    chunk.block_done = chunk_final & block_end;
    chunk.err        = ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      rd_pending  <= 1'b0;
      fwd         <= 1'b0;
      chunk_valid <= 1'b0;
      fill        <= 3'd0;
    end else if (start) begin
      busy       <= 1'b1;
      issue_left <= cmd.total;
      take_left  <= cmd.total;
      rd_ptr     <= src_addr;
      wr_ptr     <= dst_addr;
      block_end  <= cmd.block_done;
      rd_pending <= 1'b0;
      fwd        <= 1'b0;
      fill       <= 3'd0;
    end else begin
      if (issue) begin
        rd_ptr     <= rd_ptr + AW'(1);
        issue_left <= issue_left - 9'd1;
        fwd        <= consume && (rd_ptr == wr_ptr);
        fwd_data   <= cur_data;
      end
      rd_pending <= issue || (rd_pending && !consume);
      if (consume) begin
        data_buf[fill] <= cur_data;
        wr_ptr         <= wr_ptr + AW'(1);
        take_left      <= take_left - 9'd1;
        fill           <= close ? 3'd0 : fill + 3'd1;
        if (close) begin
          chunk_valid <= 1'b1;
          chunk_cnt   <= {1'b0, fill} + 4'd1;
          chunk_final <= last_take;
        end
      end
      if (chunk_valid && chunk_ready) begin
        chunk_valid <= 1'b0;
        if (chunk_final) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/lzf_block_decompressor.sv
// LZF block decompressor top level: token decoder, history ring and result register.
// Timing: a literal byte appears on the output in the cycle after it is accepted; control and
//   length-extension bytes give no result unless they raise an error; a reference is copied
//   through the ring's single read port, one byte per cycle while no finished chunk waits.
// Throughput: one compressed byte per cycle unless copying or the result slot is held full.
// Reset: synchronous, active high; clears position, decoder state, limit and output
//   valid. The ring is not cleared: a legal reference never reads an unwritten entry.
module lzf_block_decompressor #(
  parameter int WINDOW_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: declared uncompressed size
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // compressed stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  // decompressed chunks
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_byte_0..out_byte_7 [63:0], valid_count [67:64], 0
  output logic        m_axis_tlast,   // run_last
  output logic [2:0]  m_axis_tuser    // [0] block_done, [2:1] error_code
);
  import lzfd_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);

  typedef enum logic [2:0] {
    ST_CTRL,   // expect control byte
    ST_LIT,    // literal bytes due
    ST_EXT,    // length extension byte due
    ST_DIST,   // low distance byte due
    ST_DRAIN,  // error seen, drop to end of block
    ST_COPY    // copy engine running
  } state_t;

  state_t      state, state_next;
  logic [31:0] pos, pos_next;
  logic [5:0]  lit_left, lit_left_next;
  logic [8:0]  ref_len, ref_len_next;
  logic [4:0]  ref_hi, ref_hi_next;
  logic [31:0] max_out;
  logic        out_valid;
  out_item_t   out_item;

  logic        acc;
  logic [7:0]  b;
  logic        last;
  logic        emit;
  out_item_t   item;
  err_t        err;
  logic        lit_we;
  logic        copy_start;
  copy_cmd_t   copy_cmd;

  logic [5:0]  lit_cnt;
  logic        lit_ovf;
  logic [13:0] ref_dist;
  logic [8:0]  total;
  logic        before_start;
  logic        ref_ovf;

  // ring ports
  logic          copy_busy;
  logic          copy_rd_en;
  logic [AW-1:0] copy_rd_addr;
  logic          copy_wr_en;
  logic [AW-1:0] copy_wr_addr;
  logic [7:0]    copy_wr_data;
  logic [7:0]    ring_rdata;
  logic          chunk_valid;
  logic          chunk_ready;
  out_item_t     chunk;

  assign b    = s_axis_tdata;
  assign last = s_axis_tlast;

  // input waits during a copy and while the result slot is full
  assign s_axis_tready = (state != ST_COPY) && (!out_valid || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign chunk_ready   = !out_valid || m_axis_tready;

  // checks for a literal run and for a reference
  assign lit_cnt      = {1'b0, b[4:0]} + 6'd1;
  assign lit_ovf      = ({1'b0, pos} + 33'(lit_cnt)) > {1'b0, max_out};
  assign ref_dist     = {1'b0, ref_hi, b} + 14'd1;
  assign total        = ref_len + 9'd2;
  assign before_start = 32'(ref_dist) > pos;
  assign ref_ovf      = ({1'b0, pos} + 33'(total)) > {1'b0, max_out};

  assign copy_cmd.total      = total;
  assign copy_cmd.block_done = last;

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    lit_left_next = lit_left;
    ref_len_next  = ref_len;
    ref_hi_next   = ref_hi;
    emit          = 1'b0;
    item          = '0;
    err           = ERR_NONE;
    lit_we        = 1'b0;
    copy_start    = 1'b0;

    case (state)
      ST_CTRL: begin
        if (acc) begin
          if (b < LIT_LIMIT) begin
            // overflow of the whole run wins over truncation
            if (lit_ovf) begin
              err = ERR_OVERFLOW;
            end else if (last) begin
              err = ERR_TRUNCATED;
            end else begin
              lit_left_next = lit_cnt;
              state_next    = ST_LIT;
            end
          end else begin
            ref_len_next = 9'(b >> LEN_SHIFT);
            ref_hi_next  = b[4:0];
            if (last) begin
              err = ERR_TRUNCATED;
            end else begin
              state_next = (3'(b >> LEN_SHIFT) == LEN_EXTENDED) ? ST_EXT : ST_DIST;
            end
          end
        end
      end
      ST_LIT: begin
        if (acc) begin
          if (last && (lit_left > 6'd1)) begin
            err = ERR_TRUNCATED;
          end else begin
            lit_we          = 1'b1;
            pos_next        = pos + 32'd1;
            emit            = 1'b1;
            item.data[0]    = b;
            item.count      = 4'd1;
            item.run_last   = 1'b1;
            item.block_done = last;
            lit_left_next   = lit_left - 6'd1;
            if (lit_left == 6'd1) begin
              state_next = ST_CTRL;
            end
          end
        end
      end
      ST_EXT: begin
        if (acc) begin
          ref_len_next = ref_len + 9'(b);
          if (last) begin
            err = ERR_TRUNCATED;
          end else begin
            state_next = ST_DIST;
          end
        end
      end
      ST_DIST: begin
        if (acc) begin
          // reference before start is checked ahead of overflow
          if (before_start) begin
            err = ERR_BEFORE_START;
          end else if (ref_ovf) begin
            err = ERR_OVERFLOW;
          end else begin
            copy_start = 1'b1;
            pos_next   = pos + 32'(total);
            state_next = ST_COPY;
          end
        end
      end
      ST_DRAIN: begin
      end
      ST_COPY: begin
        if (!copy_busy) begin
          state_next = ST_CTRL;
        end
      end
      default: begin
        state_next = ST_CTRL;
      end
    endcase

    if (err != ERR_NONE) begin
      emit          = 1'b1;
      item          = '0;
      item.err      = err;
      item.run_last = 1'b1;
      state_next    = ST_DRAIN;
    end

    // final byte: back to block start; a running copy keeps its own pointers
    if (acc && last) begin
      pos_next      = 32'd0;
      lit_left_next = 6'd0;
      ref_len_next  = 9'd0;
      ref_hi_next   = 5'd0;
      state_next    = copy_start ? ST_COPY : ST_CTRL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CTRL;
      pos       <= 32'd0;
      lit_left  <= 6'd0;
      ref_len   <= 9'd0;
      ref_hi    <= 5'd0;
      max_out   <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      pos      <= pos_next;
      lit_left <= lit_left_next;
      ref_len  <= ref_len_next;
      ref_hi   <= ref_hi_next;
      if (cfg_we) begin
        max_out <= cfg_wdata;
      end
      if (acc && emit) begin
        out_item  <= item;
        out_valid <= 1'b1;
      end else if (chunk_valid && chunk_ready) begin
        out_item  <= chunk;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  lzfd_copy #(
    .AW (AW)
  ) u_copy (
    .clk         (clk),
    .rst         (rst),
    .start       (copy_start),
    .cmd         (copy_cmd),
    .src_addr    (pos[AW-1:0] - AW'(ref_dist)),
    .dst_addr    (pos[AW-1:0]),
    .busy        (copy_busy),
    .rd_en       (copy_rd_en),
    .rd_addr     (copy_rd_addr),
    .rd_data     (ring_rdata),
    .wr_en       (copy_wr_en),
    .wr_addr     (copy_wr_addr),
    .wr_data     (copy_wr_data),
    .chunk_valid (chunk_valid),
    .chunk_ready (chunk_ready),
    .chunk       (chunk)
  );

  // 8 KiB history ring; literals and copies share the write port
  lzfd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (copy_wr_en | lit_we),
    .waddr (copy_wr_en ? copy_wr_addr : pos[AW-1:0]),
    .wdata (copy_wr_en ? copy_wr_data : b),
    .re    (copy_rd_en),
    .raddr (copy_rd_addr),
    .rdata (ring_rdata)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_item.count, out_item.data};
  assign m_axis_tlast  = out_item.run_last;
  assign m_axis_tuser  = {out_item.err, out_item.block_done};

  // literal writes and copy writes never collide on the ring
  a_ring_write_excl: assert property (@(posedge clk) disable iff (rst)
    !(copy_wr_en && lit_we))
    else $error("ring write port claimed twice");

  // error results carry no bytes and never mark a clean end
  a_err_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[2:1] != ERR_NONE)) |->
      ((m_axis_tdata[67:64] == 4'd0) && !m_axis_tuser[0] && m_axis_tlast))
    else $error("error result with payload");

  // a copy result never leaves while the decoder is outside a copy
  a_chunk_in_copy: assert property (@(posedge clk) disable iff (rst)
    chunk_valid |-> (state == ST_COPY))
    else $error("copy chunk outside copy state");

  // chunk counts stay within one chunk
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[67:64] <= 4'd8))
    else $error("valid_count out of range");

endmodule
